FILE: sv/lldq_pkg.sv
`timescale 1ns / 1ps

package lldq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned LINK_W   = $clog2(CAPACITY + 1);
  localparam int unsigned COUNT_W  = 5;

  localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(CAPACITY);

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_INSERT     = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_POP_FRONT  = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] value;
    logic signed [31:0] search_key;
  } lldq_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic [COUNT_W-1:0] count;
  } lldq_out_t;

  typedef struct packed {
    logic             pop;
    logic             push;
    logic [IDX_W-1:0] slot;
  } lldq_free_req_t;

  function automatic logic linked(input logic [LINK_W-1:0] l);
    return l < LINK_W'(CAPACITY);
  endfunction

endpackage

FILE: sv/linked_list_deque_engine.sv
// A refused or unknown command goes from input accept straight to the result state.
// A pop reads its node and unlinks it; a push writes the new node and links any neighbour;
// an insert after key searches, reading one node per cycle from the node memories.
// Throughput: one item at a time; the next item is taken the cycle after the result
// is loaded into the output register. Asynchronous active-low reset empties the list
// and refills the free list at once; the node memories need no clearing.
`timescale 1ns / 1ps

module linked_list_deque_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lldq_pkg::lldq_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lldq_pkg::lldq_out_t out_data_o
);
  import lldq_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_WR_A = 3'd3;
  localparam logic [2:0] S_WR_B = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [2:0]         op_q, op_d;
  logic signed [31:0] val_q, val_d;
  logic signed [31:0] key_q, key_d;
  logic [LINK_W-1:0]  cur_q, cur_d;
  logic [LINK_W-1:0]  after_q, after_d;
  logic [IDX_W-1:0]   n_q, n_d;
  logic [LINK_W-1:0]  steps_q, steps_d;
  logic [LINK_W-1:0]  head_q, head_d;
  logic [LINK_W-1:0]  tail_q, tail_d;
  logic [LINK_W-1:0]  total_q, total_d;
  logic [1:0]         status_q, status_d;
  logic signed [31:0] removed_q, removed_d;
  logic               out_valid_q, out_valid_d;
  lldq_out_t          out_data_q, out_data_d;

  logic signed [31:0] val_mem [CAPACITY];
  logic [LINK_W-1:0]  nxt_mem [CAPACITY];
  logic [LINK_W-1:0]  prv_mem [CAPACITY];
  logic signed [31:0] rd_val_q;
  logic [LINK_W-1:0]  rd_nxt_q;
  logic [LINK_W-1:0]  rd_prv_q;
  logic [IDX_W-1:0]   rd_addr;

  logic               val_we, nxt_we, prv_we;
  logic [IDX_W-1:0]   val_wa, nxt_wa, prv_wa;
  logic signed [31:0] val_wd;
  logic [LINK_W-1:0]  nxt_wd, prv_wd;

  lldq_free_req_t     free_req;
  logic [IDX_W-1:0]   free_top;
  logic [LINK_W-1:0]  free_total;
  logic               in_acc;
  logic               out_acc;
  logic [LINK_W-1:0]  steps_nx;
  logic [LINK_W-1:0]  new_link;

  lldq_free_stack u_free (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (free_req),
    .top_slot_o (free_top),
    .total_o    (free_total)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign steps_nx    = steps_q + LINK_W'(1);
  assign new_link    = {{(LINK_W - IDX_W){1'b0}}, n_q};
  assign rd_addr     = (state_q == S_READ) ? cur_q[IDX_W-1:0] : rd_nxt_q[IDX_W-1:0];

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    val_d       = val_q;
    key_d       = key_q;
    cur_d       = cur_q;
    after_d     = after_q;
    n_d         = n_q;
    steps_d     = steps_q;
    head_d      = head_q;
    tail_d      = tail_q;
    total_d     = total_q;
    status_d    = status_q;
    removed_d   = removed_q;
    out_valid_d = out_valid_q && !out_acc;
    out_data_d  = out_data_q;
    val_we      = 1'b0;
    val_wa      = n_q;
    val_wd      = val_q;
    nxt_we      = 1'b0;
    nxt_wa      = n_q;
    nxt_wd      = LINK_NONE;
    prv_we      = 1'b0;
    prv_wa      = n_q;
    prv_wd      = LINK_NONE;
    free_req    = '0;
    free_req.slot = cur_q[IDX_W-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d      = in_data_i.op;
          val_d     = in_data_i.value;
          key_d     = in_data_i.search_key;
          status_d  = ST_OK;
          removed_d = '0;
          steps_d   = '0;
          state_d   = S_FIN;
          case (in_data_i.op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              if (free_total == '0) begin
                status_d = ST_FULL;
              end else begin
                state_d = S_WR_A;
              end
            end
            OP_INSERT: begin
              if (free_total == '0) begin
                status_d = ST_FULL;
              end else if (!linked(head_q)) begin
                op_d    = OP_PUSH_BACK;
                state_d = S_WR_A;
              end else begin
                cur_d   = head_q;
                state_d = S_READ;
              end
            end
            OP_POP_BACK: begin
              if (!linked(tail_q)) begin
                status_d = ST_EMPTY;
              end else begin
                cur_d   = tail_q;
                state_d = S_READ;
              end
            end
            OP_POP_FRONT: begin
              if (!linked(head_q)) begin
                status_d = ST_EMPTY;
              end else begin
                cur_d   = head_q;
                state_d = S_READ;
              end
            end
            default: begin
              state_d = S_FIN;
            end
          endcase
        end
      end
      S_READ: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        case (op_q)
          OP_INSERT: begin
            if (rd_val_q == key_q) begin
              state_d = S_WR_A;
              after_d = rd_nxt_q;
              if (cur_q == tail_q || !linked(rd_nxt_q)) begin
                op_d = OP_PUSH_BACK;
              end
            end else if (steps_nx < LINK_W'(CAPACITY) && linked(rd_nxt_q)) begin
              cur_d   = rd_nxt_q;
              steps_d = steps_nx;
            end else begin
              status_d = ST_NOT_FOUND;
              state_d  = S_FIN;
            end
          end
          OP_POP_BACK: begin
            removed_d     = rd_val_q;
            free_req.push = 1'b1;
            if (total_q != '0) begin
              total_d = total_q - LINK_W'(1);
            end
            if (cur_q == head_q || !linked(rd_prv_q)) begin
              head_d = LINK_NONE;
              tail_d = LINK_NONE;
            end else begin
              nxt_we = 1'b1;
              nxt_wa = rd_prv_q[IDX_W-1:0];
              nxt_wd = LINK_NONE;
              tail_d = rd_prv_q;
            end
            state_d = S_FIN;
          end
          default: begin
            removed_d     = rd_val_q;
            free_req.push = 1'b1;
            if (total_q != '0) begin
              total_d = total_q - LINK_W'(1);
            end
            if (cur_q == tail_q || !linked(rd_nxt_q)) begin
              head_d = LINK_NONE;
              tail_d = LINK_NONE;
            end else begin
              prv_we = 1'b1;
              prv_wa = rd_nxt_q[IDX_W-1:0];
              prv_wd = LINK_NONE;
              head_d = rd_nxt_q;
            end
            state_d = S_FIN;
          end
        endcase
      end
      S_WR_A: begin
        free_req.pop = 1'b1;
        n_d          = free_top;
        total_d      = total_q + LINK_W'(1);
        val_we       = 1'b1;
        val_wa       = free_top;
        val_wd       = val_q;
        nxt_we       = 1'b1;
        nxt_wa       = free_top;
        prv_we       = 1'b1;
        prv_wa       = free_top;
        state_d      = S_FIN;
        case (op_q)
          OP_PUSH_FRONT: begin
            prv_wd = LINK_NONE;
            nxt_wd = head_q;
            cur_d  = head_q;
            head_d = {{(LINK_W - IDX_W){1'b0}}, free_top};
            if (linked(head_q)) begin
              state_d = S_WR_B;
            end else begin
              tail_d = {{(LINK_W - IDX_W){1'b0}}, free_top};
            end
          end
          OP_PUSH_BACK: begin
            nxt_wd = LINK_NONE;
            prv_wd = tail_q;
            cur_d  = tail_q;
            tail_d = {{(LINK_W - IDX_W){1'b0}}, free_top};
            if (linked(tail_q)) begin
              state_d = S_WR_B;
            end else begin
              head_d = {{(LINK_W - IDX_W){1'b0}}, free_top};
            end
          end
          default: begin
            prv_wd  = cur_q;
            nxt_wd  = after_q;
            state_d = S_WR_B;
          end
        endcase
      end
      S_WR_B: begin
        state_d = S_FIN;
        case (op_q)
          OP_PUSH_FRONT: begin
            prv_we = 1'b1;
            prv_wa = cur_q[IDX_W-1:0];
            prv_wd = new_link;
          end
          OP_PUSH_BACK: begin
            nxt_we = 1'b1;
            nxt_wa = cur_q[IDX_W-1:0];
            nxt_wd = new_link;
          end
          default: begin
            nxt_we = 1'b1;
            nxt_wa = cur_q[IDX_W-1:0];
            nxt_wd = new_link;
            prv_we = 1'b1;
            prv_wa = after_q[IDX_W-1:0];
            prv_wd = new_link;
          end
        endcase
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d              = 1'b1;
          out_data_d.status        = status_q;
          out_data_d.removed_value = removed_q;
          out_data_d.count         = COUNT_W'(total_q);
          state_d                  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= LINK_NONE;
      tail_q      <= LINK_NONE;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    val_q      <= val_d;
    key_q      <= key_d;
    cur_q      <= cur_d;
    after_q    <= after_d;
    n_q        <= n_d;
    steps_q    <= steps_d;
    status_q   <= status_d;
    removed_q  <= removed_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[val_wa] <= val_wd;
    end
    if (nxt_we) begin
      nxt_mem[nxt_wa] <= nxt_wd;
    end
    if (prv_we) begin
      prv_mem[prv_wa] <= prv_wd;
    end
    rd_val_q <= val_mem[rd_addr];
    rd_nxt_q <= nxt_mem[rd_addr];
    rd_prv_q <= prv_mem[rd_addr];
  end

`ifndef SYNTHESIS
  a_pool_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, total_q} + {1'b0, free_total}) == (LINK_W + 1)'(CAPACITY))
    else $error("Node count and free count do not add up to the capacity.");

  a_empty_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == LINK_NONE) == (total_q == '0) && (tail_q == LINK_NONE) == (total_q == '0))
    else $error("Head or tail disagrees with the node count.");

  a_search_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL && op_q == OP_INSERT) |-> steps_q < LINK_W'(CAPACITY))
    else $error("Key search ran past the capacity.");

  a_no_pop_empty_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_req.pop |-> free_total != '0)
    else $error("Slot taken from an empty free list.");
`endif

endmodule

FILE: sv/lldq_free_stack.sv
`timescale 1ns / 1ps

module lldq_free_stack (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lldq_pkg::lldq_free_req_t     req_i,
  output logic [lldq_pkg::IDX_W-1:0]   top_slot_o,
  output logic [lldq_pkg::LINK_W-1:0]  total_o
);
  import lldq_pkg::*;

  logic [IDX_W-1:0]  slots_q [CAPACITY];
  logic [LINK_W-1:0] total_q;
  logic [LINK_W-1:0] top_pos;

  assign top_pos    = total_q - LINK_W'(1);
  assign top_slot_o = slots_q[top_pos[IDX_W-1:0]];
  assign total_o    = total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CAPACITY; i++) begin
        slots_q[i] <= IDX_W'(i);
      end
      total_q <= LINK_W'(CAPACITY);
    end else if (req_i.pop && total_q != '0) begin
      total_q <= top_pos;
    end else if (req_i.push && total_q < LINK_W'(CAPACITY)) begin
      slots_q[total_q[IDX_W-1:0]] <= req_i.slot;
      total_q <= total_q + LINK_W'(1);
    end
  end

endmodule

FILE: bench/deque_result_checker.sv
`timescale 1ns / 1ps

module deque_result_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  lldq_pkg::lldq_in_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  lldq_pkg::lldq_out_t out_data_i,
  output int                  mismatch_count_o,
  output int                  pending_o,
  output int                  accepted_o,
  output int                  ok_o,
  output int                  empty_o,
  output int                  missing_key_o,
  output int                  full_o
);

  import lldq_pkg::*;

  logic signed [31:0] node_val   [CAPACITY];
  logic [LINK_W-1:0]  next_of    [CAPACITY];
  logic [LINK_W-1:0]  prev_of    [CAPACITY];
  logic [IDX_W-1:0]   free_stack [CAPACITY];
  int                 free_n;
  int                 node_n;
  logic [LINK_W-1:0]  head;
  logic [LINK_W-1:0]  tail;
  lldq_out_t          expected_results [$];
  int                 mismatches;
  int                 accepted;
  int                 status_tally [4];

  function automatic logic [IDX_W-1:0] take_slot();
    free_n--;
    return free_stack[free_n];
  endfunction

  function automatic void append_node(input logic signed [31:0] v);
    logic [IDX_W-1:0] n;
    n = take_slot();
    node_val[n] = v;
    next_of[n]  = LINK_NONE;
    prev_of[n]  = tail;
    if (tail != LINK_NONE) begin
      next_of[tail[IDX_W-1:0]] = LINK_W'(n);
    end else begin
      head = LINK_W'(n);
    end
    tail = LINK_W'(n);
    node_n++;
  endfunction

  function automatic logic [1:0] remove_node(input logic from_back,
                                             output logic signed [31:0] v);
    logic [LINK_W-1:0] victim;
    logic [LINK_W-1:0] neighbor;
    v = '0;
    victim = from_back ? tail : head;
    if (victim == LINK_NONE) begin
      return ST_EMPTY;
    end
    v = node_val[victim[IDX_W-1:0]];
    neighbor = from_back ? prev_of[victim[IDX_W-1:0]] : next_of[victim[IDX_W-1:0]];
    if (head == tail || neighbor == LINK_NONE) begin
      head = LINK_NONE;
      tail = LINK_NONE;
    end else if (from_back) begin
      next_of[neighbor[IDX_W-1:0]] = LINK_NONE;
      tail = neighbor;
    end else begin
      prev_of[neighbor[IDX_W-1:0]] = LINK_NONE;
      head = neighbor;
    end
    if (free_n < CAPACITY) begin
      free_stack[free_n] = victim[IDX_W-1:0];
      free_n++;
    end
    if (node_n > 0) begin
      node_n--;
    end
    return ST_OK;
  endfunction

  function automatic lldq_out_t predict_result(input lldq_in_t c);
    lldq_out_t          r;
    logic [LINK_W-1:0]  cur;
    logic [LINK_W-1:0]  after;
    logic [IDX_W-1:0]   n;
    logic               found;
    logic signed [31:0] popped;
    int                 step;
    r.status        = ST_OK;
    r.removed_value = '0;
    found           = 1'b0;
    popped          = '0;
    case (c.op)
      OP_PUSH_FRONT: begin
        if (free_n == 0) begin
          r.status = ST_FULL;
        end else begin
          n = take_slot();
          node_val[n] = c.value;
          prev_of[n]  = LINK_NONE;
          next_of[n]  = head;
          if (head != LINK_NONE) begin
            prev_of[head[IDX_W-1:0]] = LINK_W'(n);
          end else begin
            tail = LINK_W'(n);
          end
          head = LINK_W'(n);
          node_n++;
        end
      end
      OP_PUSH_BACK: begin
        if (free_n == 0) begin
          r.status = ST_FULL;
        end else begin
          append_node(c.value);
        end
      end
      OP_INSERT: begin
        if (free_n == 0) begin
          r.status = ST_FULL;
        end else if (head == LINK_NONE) begin
          append_node(c.value);
        end else begin
          cur = head;
          for (step = 0; step < CAPACITY && cur != LINK_NONE && !found; step++) begin
            if (node_val[cur[IDX_W-1:0]] == c.search_key) begin
              found = 1'b1;
            end else begin
              cur = next_of[cur[IDX_W-1:0]];
            end
          end
          if (!found) begin
            r.status = ST_NOT_FOUND;
          end else begin
            after = next_of[cur[IDX_W-1:0]];
            if (cur == tail || after == LINK_NONE) begin
              append_node(c.value);
            end else begin
              n = take_slot();
              node_val[n] = c.value;
              prev_of[n]  = cur;
              next_of[n]  = after;
              next_of[cur[IDX_W-1:0]]   = LINK_W'(n);
              prev_of[after[IDX_W-1:0]] = LINK_W'(n);
              node_n++;
            end
          end
        end
      end
      OP_POP_BACK: begin
        r.status = remove_node(1'b1, popped);
        r.removed_value = popped;
      end
      OP_POP_FRONT: begin
        r.status = remove_node(1'b0, popped);
        r.removed_value = popped;
      end
      default: begin
      end
    endcase
    r.count = COUNT_W'(node_n);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lldq_out_t want;
    lldq_out_t next_want;
    if (!rst_ni) begin
      for (int i = 0; i < CAPACITY; i++) begin
        free_stack[i] = IDX_W'(i);
      end
      free_n = CAPACITY;
      node_n = 0;
      head = LINK_NONE;
      tail = LINK_NONE;
      expected_results.delete();
      mismatches = 0;
      accepted = 0;
      for (int i = 0; i < 4; i++) begin
        status_tally[i] = 0;
      end
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with no command waiting: status %0d removed %0d count %0d",
                   $time, out_data_i.status, out_data_i.removed_value, out_data_i.count);
        end else begin
          want = expected_results.pop_front();
          status_tally[want.status]++;
          if (out_data_i.status !== want.status) begin
            mismatches++;
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, out_data_i.status);
          end
          if (out_data_i.removed_value !== want.removed_value) begin
            mismatches++;
            $display("%0t: removed_value expected %0d actual %0d",
                     $time, want.removed_value, out_data_i.removed_value);
          end
          if (out_data_i.count !== want.count) begin
            mismatches++;
            $display("%0t: count expected %0d actual %0d",
                     $time, want.count, out_data_i.count);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        next_want = predict_result(in_data_i);
        expected_results = {expected_results, next_want};
        accepted++;
      end
    end
    mismatch_count_o <= mismatches;
    pending_o        <= expected_results.size();
    accepted_o       <= accepted;
    ok_o             <= status_tally[ST_OK];
    empty_o          <= status_tally[ST_EMPTY];
    missing_key_o    <= status_tally[ST_NOT_FOUND];
    full_o           <= status_tally[ST_FULL];
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  import lldq_pkg::*;

  localparam int COMMAND_TARGET = 1450;
  localparam int CYCLE_LIMIT    = 600000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = CAPACITY + 12;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  logic      in_stall;
  lldq_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  lldq_out_t out_data;

  int   mismatches;
  int   pending;
  int   accepted;
  int   n_ok;
  int   n_empty;
  int   n_missing_key;
  int   n_full;
  int   hold_requests;
  int   holds_served;
  logic quiet;
  int   cycle_count;

  linked_list_deque_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  deque_result_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_data),
    .mismatch_count_o (mismatches),
    .pending_o        (pending),
    .accepted_o       (accepted),
    .ok_o             (n_ok),
    .empty_o          (n_empty),
    .missing_key_o    (n_missing_key),
    .full_o           (n_full)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles with %0d results outstanding.",
                 cycle_count, pending);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    out_stall = 1'b0;
    holds_served = 0;
    forever begin
      @(posedge clk_i);
      if (holds_served < hold_requests) begin
        holds_served++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 28);
      end
    end
  end

  function automatic lldq_in_t make_cmd(input logic [2:0] op, input logic signed [31:0] v,
                                        input logic signed [31:0] k);
    lldq_in_t c;
    c.op         = op;
    c.value      = v;
    c.search_key = k;
    return c;
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFFFFFF;
      1:       return 32'sh80000000;
      2, 3:    return $urandom;
      default: return 32'($urandom_range(0, 5)) - 32'd2;
    endcase
  endfunction

  // Fill segments lean on pushes, drain segments on pops, mixed ones spread evenly.
  function automatic logic [2:0] pick_op(input int mode);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      return 3'($urandom_range(5, 7));
    end
    case (mode)
      0: begin
        if (r < 30) return OP_PUSH_FRONT;
        if (r < 58) return OP_PUSH_BACK;
        if (r < 85) return OP_INSERT;
        if (r < 93) return OP_POP_BACK;
        return OP_POP_FRONT;
      end
      1: begin
        if (r < 12) return OP_PUSH_FRONT;
        if (r < 22) return OP_PUSH_BACK;
        if (r < 32) return OP_INSERT;
        if (r < 66) return OP_POP_BACK;
        return OP_POP_FRONT;
      end
      default: begin
        if (r < 22) return OP_PUSH_FRONT;
        if (r < 41) return OP_PUSH_BACK;
        if (r < 62) return OP_INSERT;
        if (r < 81) return OP_POP_BACK;
        return OP_POP_FRONT;
      end
    endcase
  endfunction

  task automatic send_command(input lldq_in_t c);
    while (!quiet && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    lldq_in_t c;
    int       sent;
    int       seg;
    int       seg_len;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    quiet = 1'b0;
    hold_requests = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_command(make_cmd(OP_POP_BACK, 32'sd0, 32'sd0));
    send_command(make_cmd(OP_POP_FRONT, 32'sd0, 32'sd0));
    send_command(make_cmd(OP_INSERT, 32'sh7FFFFFFF, 32'sh80000000));
    send_command(make_cmd(OP_PUSH_FRONT, 32'sh80000000, 32'sd0));
    send_command(make_cmd(OP_PUSH_BACK, 32'sd0, 32'sd0));
    send_command(make_cmd(OP_PUSH_BACK, -32'sd1, 32'sd0));
    send_command(make_cmd(OP_INSERT, 32'sd5, 32'sh7FFFFFFF));
    send_command(make_cmd(OP_INSERT, 32'sd9, 32'sd12345));
    send_command(make_cmd(OP_INSERT, 32'sd7, -32'sd1));
    send_command(make_cmd(3'd5, 32'sh7FFFFFFF, 32'sh7FFFFFFF));
    send_command(make_cmd(3'd6, 32'sh80000000, 32'sh80000000));
    send_command(make_cmd(3'd7, -32'sd1, -32'sd1));
    send_command(make_cmd(OP_POP_FRONT, 32'sd0, 32'sd0));
    send_command(make_cmd(OP_POP_BACK, 32'sd0, 32'sd0));
    for (int i = 0; i < 12; i++) begin
      send_command(make_cmd(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK,
                            i[1] ? 32'sh7FFFFFFF : 32'sh80000000 + i, 32'sd0));
    end
    send_command(make_cmd(OP_PUSH_FRONT, 32'sd1, 32'sd0));
    send_command(make_cmd(OP_PUSH_BACK, 32'sd1, 32'sd0));
    send_command(make_cmd(OP_INSERT, 32'sd1, 32'sh7FFFFFFF));

    sent = 0;
    seg = 0;
    while (sent < COMMAND_TARGET) begin
      quiet = (seg == 6);
      if (seg == 3) begin
        hold_requests++;
      end
      if (seg % 5 == 4) begin
        wait_for_results();
      end
      seg_len = $urandom_range(20, 60);
      repeat (seg_len) begin
        c = make_cmd(pick_op(seg % 3), pick_value(), pick_value());
        send_command(c);
        if (c.op <= OP_POP_FRONT) begin
          sent++;
        end
      end
      seg++;
    end
    quiet = 1'b0;

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d commands: %0d ok, %0d pops on an empty list, %0d keys not found,",
             accepted, n_ok, n_empty, n_missing_key);
    $display("and %0d refused on a full pool, across fill, drain and mixed phases.", n_full);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
